// File: design/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad code lock
// Result codes, configuration register indexes, reset values and the
// command bundle from the decision logic to the storage units.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int KEY_W    = 8;
  localparam int MIN_W    = 4;
  localparam int HELD_W   = 4;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_KEY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS = 1'b1;

  // Configuration reset values
  localparam logic [KEY_W-1:0] ENTER_KEY_RESET  = 8'd68;
  localparam logic [MIN_W-1:0] MIN_DIGITS_RESET = 4'd4;

  // Result status codes
  typedef enum logic [2:0] {
    STATUS_DIGIT   = 3'd0,
    STATUS_SHORT   = 3'd1,
    STATUS_LONG    = 3'd2,
    STATUS_STORED  = 3'd3,
    STATUS_CORRECT = 3'd4,
    STATUS_WRONG   = 3'd5
  } status_t;

  // Update commands for one processed item
  typedef struct packed {
    logic append;
    logic clear;
    logic enroll;
  } entry_cmd_t;

endpackage

// File: design/keypad_code_lock_top.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_top: keypad combination lock
// Takes one key code per item and returns one status item per key.
// ----------------------------------------------------------------------------
// The lock accepts one key per clock cycle and returns exactly one result
// per key: the key is captured in an input register, decided against the
// entry buffer and the enrolled code, and written with the updated state
// into the result register. The entry and code state change as a key
// leaves the input register, so the following key already sees them.
// Throughput drops only while the result register is held by out_stall.
// Configuration writes are meant for idle periods only.
module keypad_code_lock_top #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            wr_en,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [kcl_pkg::KEY_W-1:0]       wr_data,
  // key channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kcl_pkg::KEY_W-1:0]       key_code,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      status,
  output logic [kcl_pkg::HELD_W-1:0]      digits_held
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int CMP_W = (CNT_W > kcl_pkg::MIN_W) ? CNT_W : kcl_pkg::MIN_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

  logic [kcl_pkg::KEY_W-1:0]  enter_key_code;
  logic [kcl_pkg::MIN_W-1:0]  min_digits;

  logic                       s1_valid;
  logic [kcl_pkg::KEY_W-1:0]  s1_key;
  logic                       advance;

  logic [CNT_W-1:0]                          entry_count;
  logic [MAX_DIGITS-1:0][kcl_pkg::KEY_W-1:0] entry_digits;
  logic                                      enrolled;
  logic                                      match;

  kcl_pkg::entry_cmd_t        dec_cmd;
  kcl_pkg::entry_cmd_t        cmd;
  kcl_pkg::status_t           status_next;
  logic [CNT_W-1:0]           count_next;

  kcl_pkg::status_t           out_status;
  logic [kcl_pkg::HELD_W-1:0] out_held;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enter_key_code <= kcl_pkg::ENTER_KEY_RESET;
      min_digits     <= kcl_pkg::MIN_DIGITS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        kcl_pkg::CFG_ENTER_KEY:  enter_key_code <= wr_data;
        kcl_pkg::CFG_MIN_DIGITS: min_digits     <= wr_data[kcl_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on when the result register frees up
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_key <= key_code;
    end
  end

  // Decide the outcome of the key in the input register
  always_comb begin
    dec_cmd     = '0;
    status_next = kcl_pkg::STATUS_DIGIT;
    count_next  = '0;
    if (s1_key != enter_key_code) begin
      if (entry_count < MAX_CNT) begin
        dec_cmd.append = 1'b1;
        count_next     = entry_count + CNT_W'(1);
      end else begin
        dec_cmd.clear = 1'b1;
        status_next   = kcl_pkg::STATUS_LONG;
      end
    end else if (CMP_W'(entry_count) < CMP_W'(min_digits)) begin
      dec_cmd.clear = 1'b1;
      status_next   = kcl_pkg::STATUS_SHORT;
    end else if (!enrolled) begin
      dec_cmd.clear  = 1'b1;
      dec_cmd.enroll = 1'b1;
      status_next    = kcl_pkg::STATUS_STORED;
    end else begin
      dec_cmd.clear = 1'b1;
      status_next   = match ? kcl_pkg::STATUS_CORRECT : kcl_pkg::STATUS_WRONG;
    end
  end

  // Commit state only when the item moves to the result register
  assign cmd = advance ? dec_cmd : '0;

  kcl_entry #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_entry (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .key    (s1_key),
    .count  (entry_count),
    .digits (entry_digits)
  );

  kcl_code_store #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_code_store (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .entry_count  (entry_count),
    .entry_digits (entry_digits),
    .enrolled     (enrolled),
    .match        (match)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= status_next;
      out_held   <= kcl_pkg::HELD_W'(count_next);
    end
  end

  assign status      = out_status;
  assign digits_held = out_held;

endmodule

// File: design/kcl_entry.sv
// ----------------------------------------------------------------------------
// kcl_entry: entry buffer of the keypad code lock
// Holds the digits typed since the last clear and their count.
// ----------------------------------------------------------------------------
module kcl_entry #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  kcl_pkg::entry_cmd_t                      cmd,
  input  logic [kcl_pkg::KEY_W-1:0]                key,
  output logic [$clog2(MAX_DIGITS+1)-1:0]          count,
  output logic [MAX_DIGITS-1:0][kcl_pkg::KEY_W-1:0] digits
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);

  logic [MAX_DIGITS-1:0][kcl_pkg::KEY_W-1:0] entry_buffer;
  logic [CNT_W-1:0]                          entry_count;

  // Advance the count on append, drop it on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.append) begin
      entry_count <= entry_count + CNT_W'(1);
    end else if (cmd.clear) begin
      entry_count <= '0;
    end
  end

  // Store the digit at the next free position
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      entry_buffer[entry_count[IDX_W-1:0]] <= key;
    end
  end

  assign count  = entry_count;
  assign digits = entry_buffer;

endmodule

// File: design/kcl_code_store.sv
// ----------------------------------------------------------------------------
// kcl_code_store: enrolled code of the keypad code lock
// Keeps the enrolled code and its length and compares the entry against it.
// ----------------------------------------------------------------------------
module kcl_code_store #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  kcl_pkg::entry_cmd_t                       cmd,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]           entry_count,
  input  logic [MAX_DIGITS-1:0][kcl_pkg::KEY_W-1:0] entry_digits,
  output logic                                      enrolled,
  output logic                                      match
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [MAX_DIGITS-1:0][kcl_pkg::KEY_W-1:0] stored_code;
  logic [CNT_W-1:0]                          stored_length;
  logic                                      code_enrolled;
  logic [MAX_DIGITS-1:0]                     digit_ok;

  // Take the entry as the code on enrollment
  always_ff @(posedge clk) begin
    if (rst) begin
      code_enrolled <= 1'b0;
      stored_length <= '0;
    end else if (cmd.enroll) begin
      code_enrolled <= 1'b1;
      stored_length <= entry_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.enroll) begin
      stored_code <= entry_digits;
    end
  end

  // Compare every position in parallel; positions past the entry always pass
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digit_ok[i] = (CNT_W'(i) >= entry_count) || (entry_digits[i] == stored_code[i]);
    end
  end

  assign match    = (entry_count == stored_length) && (&digit_ok);
  assign enrolled = code_enrolled;

endmodule
